FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the PID block, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define PIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check at every edge, reset included.
`define PIS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: design/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// Shared widths, codes and the command type of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int LIMIT_W   = 31;
    localparam int DIV_W     = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int IN_DW     = 2 * DATA_W;
    localparam int MODE_W    = 2;

    localparam logic [LIMIT_W-1:0] DT_RESET = LIMIT_W'(1 << FRAC_W);

    typedef enum logic [2:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_I_LIMIT,
        REG_I_THRESHOLD,
        REG_I_STOP,
        REG_OUTPUT_LIMIT,
        REG_DT
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE,
        MODE_RESET,
        MODE_CLEAR,
        MODE_SET
    } mode_t;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_MUL,
        OP_DIV_LOAD,
        OP_DIV_STEP
    } arith_op_t;

    typedef struct packed {
        arith_op_t                op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } arith_cmd_t;

endpackage

FILE: design/pis_arith.sv
// ----------------------------------------------------------------------------
// pis_arith
// Shared arithmetic unit: one signed multiply per command, or one restoring
// divide step per command on a fraction-scaled magnitude.
// ----------------------------------------------------------------------------
module pis_arith (
    input  logic                                aclk,
    input  pis_pkg::arith_cmd_t                 cmd,
    output logic signed [2*pis_pkg::DATA_W-1:0] prod,
    output logic [pis_pkg::DIV_W-1:0]           quo
);
    import pis_pkg::*;

    logic signed [2*DATA_W-1:0] prod_reg;
    logic [DIV_W-1:0]           quo_reg;
    logic [DATA_W-1:0]          rem_reg;
    logic [LIMIT_W-1:0]         den_reg;
    logic [DATA_W-1:0]          rem_shift;
    logic                       fits;

    // shift in the next numerator bit; the remainder stays below the divisor
    assign rem_shift = {rem_reg[DATA_W-2:0], quo_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_MUL: begin
                prod_reg <= (2*DATA_W)'(cmd.a) * (2*DATA_W)'(cmd.b);
            end
            OP_DIV_LOAD: begin
                quo_reg <= {cmd.a, {FRAC_W{1'b0}}};
                rem_reg <= '0;
                den_reg <= cmd.b[LIMIT_W-1:0];
            end
            OP_DIV_STEP: begin
                rem_reg <= fits ? rem_shift - {1'b0, den_reg} : rem_shift;
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
            end
            default: begin
            end
        endcase
    end

    assign prod = prod_reg;
    assign quo  = quo_reg;

endmodule

FILE: design/pid_integral_separation.sv
// ----------------------------------------------------------------------------
// pid_integral_separation
// PID controller in signed Q16.16 with integral separation, integral and
// output clamps, driven by a stream of commands with an APB register port.
// ----------------------------------------------------------------------------
// An update beat shows its drive once the sequencer has run its steps; the
//   48 single-bit divide steps of the derivative dominate. Other modes go straight to S_DONE.
// Flow: a new beat is accepted only once the last one has been presented;
//   s_tready is high only while the sequencer idles.
// Reset (aresetn low, synchronous): registers to defaults (dt = 1.0), state
//   cleared, no beat pending on m_.
`include "assert_macros.svh"

module pid_integral_separation (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pis_pkg::APB_AW-1:0]      paddr,
    input  logic [pis_pkg::APB_DW-1:0]      pwdata,
    output logic [pis_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pis_pkg::IN_DW-1:0]       s_tdata,  // [31:0] error_in, [63:32] integral_value
    input  logic [pis_pkg::MODE_W-1:0]      s_tuser,  // [1:0] mode
    // drive stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pis_pkg::DATA_W-1:0]      m_tdata   // [31:0] drive
);
    import pis_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_EDT,
        S_INT_SCALE,
        S_INT_UPD,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_DIV_FIN,
        S_MUL_P,
        S_ACC_P,
        S_MUL_I,
        S_ACC_I,
        S_MUL_D,
        S_ACC_D,
        S_DONE
    } state_t;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------
    // saturate a sum two bits wider than the data path
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (!v[DATA_W+1] && (|v[DATA_W:DATA_W-1])) begin
            r = SMAX;
        end else if (v[DATA_W+1] && !(&v[DATA_W:DATA_W-1])) begin
            r = SMIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // rescale a full product: floor shift by the fraction bits, then saturate
    function automatic logic signed [DATA_W-1:0] qscale(input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] sh;
        logic signed [DATA_W-1:0]   r;
        sh = p >>> FRAC_W;
        if (!sh[2*DATA_W-1] && (|sh[2*DATA_W-2:DATA_W-1])) begin
            r = SMAX;
        end else if (sh[2*DATA_W-1] && !(&sh[2*DATA_W-2:DATA_W-1])) begin
            r = SMIN;
        end else begin
            r = sh[DATA_W-1:0];
        end
        return r;
    endfunction

    // clamp to +-lim
    function automatic logic signed [DATA_W-1:0] clamp_mag(input logic signed [DATA_W-1:0] v,
                                                           input logic [LIMIT_W-1:0] lim);
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] neg;
        logic signed [DATA_W-1:0] r;
        pos = signed'({1'b0, lim});
        neg = -pos;
        if (v > pos) begin
            r = pos;
        end else if (v < neg) begin
            r = neg;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] kp_reg, kp_next;
    logic signed [DATA_W-1:0] ki_reg, ki_next;
    logic signed [DATA_W-1:0] kd_reg, kd_next;
    logic [LIMIT_W-1:0]       i_limit_reg, i_limit_next;
    logic [LIMIT_W-1:0]       i_thresh_reg, i_thresh_next;
    logic [LIMIT_W-1:0]       i_stop_reg, i_stop_next;
    logic [LIMIT_W-1:0]       out_limit_reg, out_limit_next;
    logic [LIMIT_W-1:0]       dt_reg, dt_next;
    logic signed [DATA_W-1:0] prev_err_reg, prev_err_next;
    logic signed [DATA_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next;    // scaled error*dt, then deriv
    logic signed [DATA_W-1:0] diff_reg, diff_next;
    logic signed [DATA_W+1:0] sum_reg, sum_next;    // running p + i + d
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]        m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Shared arithmetic unit
    // ------------------------------------------------------------------
    arith_cmd_t                 cmd;
    logic signed [2*DATA_W-1:0] prod;
    logic [DIV_W-1:0]           quo;

    pis_arith u_arith (
        .aclk (aclk),
        .cmd  (cmd),
        .prod (prod),
        .quo  (quo)
    );

    // ------------------------------------------------------------------
    // Datapath terms
    // ------------------------------------------------------------------
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;
    logic                     s_fire;
    logic                     out_free;
    logic [DATA_W-1:0]        err_mag;
    logic [DATA_W-1:0]        diff_mag;
    logic signed [DATA_W-1:0] integ_acc;
    logic signed [DATA_W-1:0] integ_upd;
    logic signed [DATA_W-1:0] deriv;
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] drive;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = reg_idx_t'(paddr[APB_AW-1:2]);
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // magnitudes as unsigned; the most negative value maps to 2^31
    assign err_mag  = err_reg[DATA_W-1]  ? DATA_W'(-err_reg)  : DATA_W'(err_reg);
    assign diff_mag = diff_reg[DATA_W-1] ? DATA_W'(-diff_reg) : DATA_W'(diff_reg);
    assign scaled   = qscale(prod);
    assign integ_acc = sat_wide((DATA_W+2)'(integ_reg) + (DATA_W+2)'(tmp_reg));

    // integral separation: accumulate inside the threshold band, drop outside,
    // drop inside the stop band, then clamp if i_limit is nonzero
    always_comb begin
        integ_upd = (err_mag < {1'b0, i_thresh_reg}) ? integ_acc : '0;
        if (err_mag < {1'b0, i_stop_reg}) begin
            integ_upd = '0;
        end
        if (i_limit_reg != '0) begin
            integ_upd = clamp_mag(integ_upd, i_limit_reg);
        end
    end

    // apply sign and saturate the divide result; zero dt saturates by sign
    always_comb begin
        if (dt_reg == '0) begin
            if (diff_reg > 0) begin
                deriv = SMAX;
            end else if (diff_reg < 0) begin
                deriv = SMIN;
            end else begin
                deriv = '0;
            end
        end else if (!diff_reg[DATA_W-1]) begin
            deriv = (|quo[DIV_W-1:DATA_W-1]) ? SMAX : signed'(quo[DATA_W-1:0]);
        end else begin
            deriv = (|quo[DIV_W-1:DATA_W-1]) ? SMIN : -signed'(quo[DATA_W-1:0]);
        end
    end

    // final sum, saturated and, if out_limit is nonzero, clamped; non-update beats carry a zero sum
    always_comb begin
        drive = sat_wide(sum_reg);
        if (out_limit_reg != '0) begin
            drive = clamp_mag(drive, out_limit_reg);
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_KP:           prdata = kp_reg;
            REG_KI:           prdata = ki_reg;
            REG_KD:           prdata = kd_reg;
            REG_I_LIMIT:      prdata = {1'b0, i_limit_reg};
            REG_I_THRESHOLD:  prdata = {1'b0, i_thresh_reg};
            REG_I_STOP:       prdata = {1'b0, i_stop_reg};
            REG_OUTPUT_LIMIT: prdata = {1'b0, out_limit_reg};
            REG_DT:           prdata = {1'b0, dt_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        kd_next        = kd_reg;
        i_limit_next   = i_limit_reg;
        i_thresh_next  = i_thresh_reg;
        i_stop_next    = i_stop_reg;
        out_limit_next = out_limit_reg;
        dt_next        = dt_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        err_next       = err_reg;
        tmp_next       = tmp_reg;
        diff_next      = diff_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        cmd            = '{op: OP_IDLE, a: '0, b: '0};

        // register writes take effect at once; the host must write only while
        // the sequencer idles: the block itself does not enforce this
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KP:           kp_next        = pwdata;
                REG_KI:           ki_next        = pwdata;
                REG_KD:           kd_next        = pwdata;
                REG_I_LIMIT:      i_limit_next   = pwdata[LIMIT_W-1:0];
                REG_I_THRESHOLD:  i_thresh_next  = pwdata[LIMIT_W-1:0];
                REG_I_STOP:       i_stop_next    = pwdata[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT: out_limit_next = pwdata[LIMIT_W-1:0];
                REG_DT:           dt_next        = pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    sum_next = '0;
                    unique case (mode_t'(s_tuser))
                        MODE_UPDATE: begin
                            err_next   = s_tdata[DATA_W-1:0];
                            state_next = S_MUL_EDT;
                        end
                        MODE_RESET: begin
                            prev_err_next = '0;
                            integ_next    = '0;
                            state_next    = S_DONE;
                        end
                        MODE_CLEAR: begin
                            integ_next = '0;
                            state_next = S_DONE;
                        end
                        MODE_SET: begin
                            integ_next = s_tdata[IN_DW-1:DATA_W];
                            state_next = S_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL_EDT: begin
                cmd        = '{op: OP_MUL, a: err_reg, b: signed'({1'b0, dt_reg})};
                state_next = S_INT_SCALE;
            end
            S_INT_SCALE: begin
                tmp_next   = scaled;
                state_next = S_INT_UPD;
            end
            S_INT_UPD: begin
                integ_next    = integ_upd;
                diff_next     = sat_wide((DATA_W+2)'(err_reg) - (DATA_W+2)'(prev_err_reg));
                prev_err_next = err_reg;
                state_next    = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                cmd        = '{op: OP_DIV_LOAD, a: signed'(diff_mag),
                               b: signed'({1'b0, dt_reg})};
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                // one quotient bit per cycle
                cmd      = '{op: OP_DIV_STEP, a: '0, b: '0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    state_next = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                tmp_next   = deriv;
                state_next = S_MUL_P;
            end
            S_MUL_P: begin
                cmd        = '{op: OP_MUL, a: kp_reg, b: err_reg};
                state_next = S_ACC_P;
            end
            S_ACC_P: begin
                sum_next   = (DATA_W+2)'(scaled);
                state_next = S_MUL_I;
            end
            S_MUL_I: begin
                cmd        = '{op: OP_MUL, a: ki_reg, b: integ_reg};
                state_next = S_ACC_I;
            end
            S_ACC_I: begin
                sum_next   = sum_reg + (DATA_W+2)'(scaled);
                state_next = S_MUL_D;
            end
            S_MUL_D: begin
                cmd        = '{op: OP_MUL, a: kd_reg, b: tmp_reg};
                state_next = S_ACC_D;
            end
            S_ACC_D: begin
                sum_next   = sum_reg + (DATA_W+2)'(scaled);
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free, then present the beat
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = drive;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            i_limit_reg   <= '0;
            i_thresh_reg  <= '0;
            i_stop_reg    <= '0;
            out_limit_reg <= '0;
            dt_reg        <= DT_RESET;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            i_limit_reg   <= i_limit_next;
            i_thresh_reg  <= i_thresh_next;
            i_stop_reg    <= i_stop_next;
            out_limit_reg <= out_limit_next;
            dt_reg        <= dt_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            err_reg       <= err_next;
            tmp_reg       <= tmp_next;
            diff_reg      <= diff_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] i_lim_pos;
    logic signed [DATA_W-1:0] i_lim_neg;

    assign i_lim_pos = signed'({1'b0, i_limit_reg});
    assign i_lim_neg = -i_lim_pos;

    `PIS_ASSERT(a_integ_clamped, (state_reg == S_INT_UPD && i_limit_reg != '0) |=> (integ_reg <= i_lim_pos && integ_reg >= i_lim_neg), "integral outside its clamp after update")
    `PIS_ASSERT(a_div_full_run, (state_reg == S_DIV_FIN) |-> ($past(state_reg) == S_DIV_STEP && $past(cnt_reg) == DIV_CNT_W'(DIV_W - 1)), "derivative taken before all divide steps")
    `PIS_ASSERT(a_beat_from_done, $rose(m_tvalid) |-> ($past(state_reg) == S_DONE), "result beat raised outside the done state")
    `PIS_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (state_reg == S_IDLE && !m_tvalid), "reset left the sequencer busy")

endmodule
